// ----- design/slcd_pkg.sv -----
`timescale 1ns / 1ps

package slcd_pkg;

    localparam int IMAGE_BYTES = 21;
    localparam int DIGIT_SLOTS = 7;
    localparam int IDX_W       = $clog2(IMAGE_BYTES);

    // slots whose upper neighbor still lies inside the image
    localparam int SLOTS_FIT  = (IMAGE_BYTES - 3) / 3 + 1;
    localparam int SLOTS_USED = (DIGIT_SLOTS < SLOTS_FIT) ? DIGIT_SLOTS : SLOTS_FIT;
    localparam int SLOT_W     = $clog2(SLOTS_USED + 1);

    localparam int NUM_W      = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = NUM_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef enum logic [2:0] {
        OP_SHOW    = 3'd0,
        OP_SET     = 3'd1,
        OP_CLR     = 3'd2,
        OP_CLR_ALL = 3'd3,
        OP_REFRESH = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_DIV,
        ST_LO,
        ST_HI,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } t_img_wr;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
        logic [3:0]       rem;
    } t_div_out;

    function automatic logic [7:0] digit_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hAF;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h6D;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'hC6;
            4'd5:    code = 8'hCB;
            4'd6:    code = 8'hEB;
            4'd7:    code = 8'h8E;
            4'd8:    code = 8'hEF;
            4'd9:    code = 8'hCF;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// ----- design/segment_lcd_buffer_controller.sv -----
`timescale 1ns / 1ps

// Segment image controller for a seven-digit LCD, 21 image bytes.
// Input channel (i_in_valid / o_in_ready) takes one command per transaction:
// show number, set or clear a symbol bit, clear all, or refresh.
// Output channel (o_out_valid / i_out_ready) carries address/data frames;
// o_last marks the final frame of a clear-all or refresh run.
// Set and clear bit finish in the cycle they are taken; the block is ready
// again on the next cycle. Show number walks the seven digit slots with one
// shared divide-by-ten unit that resolves four quotient bits per cycle;
// once the number is zero, a slot skips the divide and keeps its old
// middle byte. Clear all and refresh emit 21 frames, one per
// cycle while the receiver keeps up; the emit state entered after the
// command loads each frame. A stalled receiver holds the current frame and
// pauses the run, and no new command is taken until the run has been handed
// to the output register. Reset empties the image to all zero and drops any
// pending frame.
module segment_lcd_buffer_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_op,
    input  logic [31:0] i_number,
    input  logic [5:0] i_symbol_address,
    input  logic [2:0] i_symbol_bit,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_seg_address,
    output logic [7:0] o_seg_data,
    output logic       o_last
);
    import slcd_pkg::*;

    t_state             r_state, n_state;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [IDX_W-1:0]   r_mid, n_mid;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_clr, n_clr;
    logic               r_out_valid, n_out_valid;
    logic [4:0]         r_seg_address, n_seg_address;
    logic [7:0]         r_seg_data, n_seg_data;
    logic               r_last, n_last;

    t_img_wr            img_wr;
    logic [IDX_W-1:0]   rd_addr;
    logic [7:0]         rd_data;
    logic               div_start;
    t_div_out           div_res;
    logic               in_acc;
    logic               out_free;
    logic [IDX_W-1:0]   sym_idx;
    logic               sym_ok;
    logic [7:0]         bit_mask;

    slcd_image u_image (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (img_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    slcd_div10 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_num),
        .o_res      (div_res)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign sym_ok     = (i_symbol_address <= 6'(IMAGE_BYTES - 1));
    assign sym_idx    = IDX_W'(IMAGE_BYTES - 1) - IDX_W'(i_symbol_address);
    assign bit_mask   = 8'd1 << i_symbol_bit;

    always_comb begin
        n_state       = r_state;
        n_num         = r_num;
        n_slot        = r_slot;
        n_mid         = r_mid;
        n_idx         = r_idx;
        n_clr         = r_clr;
        n_seg_address = r_seg_address;
        n_seg_data    = r_seg_data;
        n_last        = r_last;
        n_out_valid   = r_out_valid && !i_out_ready;
        img_wr.en     = 1'b0;
        img_wr.addr   = r_mid;
        img_wr.data   = rd_data;
        rd_addr       = r_mid;
        div_start     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                rd_addr = sym_idx;
                if (in_acc) begin
                    case (i_op)
                        OP_SHOW: begin
                            n_num   = i_number;
                            n_slot  = '0;
                            n_mid   = IDX_W'(1);
                            n_state = ST_SLOT;
                        end
                        OP_SET: begin
                            img_wr.en   = sym_ok;
                            img_wr.addr = sym_idx;
                            img_wr.data = rd_data | bit_mask;
                        end
                        OP_CLR: begin
                            img_wr.en   = sym_ok;
                            img_wr.addr = sym_idx;
                            img_wr.data = rd_data & ~bit_mask;
                        end
                        OP_CLR_ALL: begin
                            n_idx   = '0;
                            n_clr   = 1'b1;
                            n_state = ST_EMIT;
                        end
                        OP_REFRESH: begin
                            n_idx   = '0;
                            n_clr   = 1'b0;
                            n_state = ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SLOT: begin
                // an exhausted number keeps the old middle byte
                if (r_num != '0) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_LO;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    img_wr.en   = 1'b1;
                    img_wr.addr = r_mid;
                    img_wr.data = digit_code(div_res.rem);
                    n_num       = div_res.quot;
                    n_state     = ST_LO;
                end
            end
            ST_LO: begin
                img_wr.en   = 1'b1;
                img_wr.addr = r_mid - IDX_W'(1);
                img_wr.data = {rd_data[3:0], 4'h0};
                n_state     = ST_HI;
            end
            ST_HI: begin
                img_wr.en   = 1'b1;
                img_wr.addr = r_mid + IDX_W'(1);
                img_wr.data = {4'h0, rd_data[7:4]};
                if (r_slot == SLOT_W'(SLOTS_USED - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_mid   = r_mid + IDX_W'(3);
                    n_state = ST_SLOT;
                end
            end
            ST_EMIT: begin
                rd_addr = r_idx;
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_seg_address = r_clr ? 5'(r_idx)
                                          : 5'(IDX_W'(IMAGE_BYTES - 1) - r_idx);
                    n_seg_data    = r_clr ? 8'h00 : rd_data;
                    n_last        = (r_idx == IDX_W'(IMAGE_BYTES - 1));
                    img_wr.en     = r_clr;
                    img_wr.addr   = r_idx;
                    img_wr.data   = 8'h00;
                    n_idx         = r_idx + 1'b1;
                    if (r_idx == IDX_W'(IMAGE_BYTES - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_slot      <= '0;
            r_idx       <= '0;
            r_clr       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_slot      <= n_slot;
            r_idx       <= n_idx;
            r_clr       <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num         <= n_num;
        r_mid         <= n_mid;
        r_seg_address <= n_seg_address;
        r_seg_data    <= n_seg_data;
        r_last        <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_seg_address = r_seg_address;
    assign o_seg_data    = r_seg_data;
    assign o_last        = r_last;

endmodule

// ----- design/slcd_div10.sv -----
`timescale 1ns / 1ps

module slcd_div10 (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [slcd_pkg::NUM_W-1:0] i_dividend,
    output slcd_pkg::t_div_out       o_res
);
    import slcd_pkg::*;

    logic [NUM_W-1:0]     r_work, n_work;
    logic [3:0]           r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // restoring division by ten, DIV_STEP quotient bits per cycle
    always_comb begin
        logic [4:0]       rem;
        logic [NUM_W-1:0] work;
        rem  = {1'b0, r_rem};
        work = r_work;
        for (int k = 0; k < DIV_STEP; k++) begin
            rem = {rem[3:0], work[NUM_W-1]};
            if (rem >= 5'd10) begin
                rem  = rem - 5'd10;
                work = {work[NUM_W-2:0], 1'b1};
            end else begin
                work = {work[NUM_W-2:0], 1'b0};
            end
        end
        n_rem  = rem[3:0];
        n_work = work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_work;
    assign o_res.rem  = r_rem;

endmodule

// ----- design/slcd_image.sv -----
`timescale 1ns / 1ps

module slcd_image (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  slcd_pkg::t_img_wr          i_wr,
    input  logic [slcd_pkg::IDX_W-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);
    import slcd_pkg::*;

    logic [7:0] r_img [IMAGE_BYTES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < IMAGE_BYTES; k++) begin
                r_img[k] <= 8'h00;
            end
        end else if (i_wr.en && (i_wr.addr <= IDX_W'(IMAGE_BYTES - 1))) begin
            r_img[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = (i_rd_addr <= IDX_W'(IMAGE_BYTES - 1)) ? r_img[i_rd_addr] : 8'h00;

endmodule
